// File: src/oli_pkg.sv
// ----------------------------------------------------------------------------
// oli_pkg
// shared types and constants for the ordered list with insert and remove
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int unsigned Capacity = 16;
  localparam int unsigned CntW     = $clog2(Capacity + 1);
  localparam int unsigned IdxW     = $clog2(Capacity);
  localparam int unsigned ValW     = 32;
  localparam int unsigned OpW      = 2;
  localparam int unsigned StW      = 2;
  localparam int unsigned LenW     = 5;

  typedef enum logic [OpW-1:0] {
    OP_INS_FRONT = 2'd0,
    OP_INS_BACK  = 2'd1,
    OP_REMOVE    = 2'd2
  } op_e;

  typedef enum logic [StW-1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_e;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic shift_back;   // insert at front, every entry moves back
    logic append;       // insert at back, cell at current count takes value
    logic remove;       // remove first match, later entries move forward
  } cell_ctrl_t;

endpackage

// File: src/oli_if.sv
// ----------------------------------------------------------------------------
// oli_req_if / oli_rsp_if
// valid/ready channels carrying list requests and their results
// ----------------------------------------------------------------------------
interface oli_req_if;
  import oli_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [OpW-1:0]         opcode;
  logic signed [ValW-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface oli_rsp_if;
  import oli_pkg::*;

  logic            valid;
  logic            ready;
  logic [StW-1:0]  status;
  logic [LenW-1:0] length;

  modport source (output valid, output status, output length, input ready);
  modport sink   (input valid, input status, input length, output ready);
endinterface

// File: src/oli_cell.sv
// ----------------------------------------------------------------------------
// oli_cell
// one list position: holds an entry, matches it, shifts with its neighbors
// ----------------------------------------------------------------------------
module oli_cell
  import oli_pkg::*;
(
  input  logic                   clk_i,
  input  logic [IdxW-1:0]        idx_i,
  input  logic [CntW-1:0]        count_i,
  input  cell_ctrl_t             ctrl_i,
  input  logic signed [ValW-1:0] value_i,
  input  logic signed [ValW-1:0] prev_i,
  input  logic signed [ValW-1:0] next_i,
  input  logic                   hit_i,
  output logic                   hit_o,
  output logic signed [ValW-1:0] data_o
);

  logic signed [ValW-1:0] data_q, data_d;
  logic                   occupied;
  logic                   is_front;
  logic                   is_tail;

  assign occupied = CntW'(idx_i) < count_i;
  assign is_front = idx_i == '0;
  assign is_tail  = CntW'(idx_i) == count_i;

  // hit travels toward the back once the first match has been seen
  assign hit_o = hit_i | (occupied & (data_q == value_i));

  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_back) begin
      data_d = is_front ? value_i : prev_i;
    end else if (ctrl_i.append && is_tail) begin
      data_d = value_i;
    end else if (ctrl_i.remove && hit_o) begin
      data_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// File: src/ordered_list_insert_remove.sv
// ----------------------------------------------------------------------------
// ordered_list_insert_remove
// ordered list of signed 32-bit values with front insert, back insert and
// remove of the first match, built as a row of shifting cells
// ----------------------------------------------------------------------------
//  channel  dir  fields                 meaning
//  req_i    in   opcode[1:0], value[31:0]  one list operation per request
//  rsp_o    out  status[1:0], length[4:0]  one result per request
//
//  one request per cycle while rsp_o is not stalled: every cell compares and shifts in the same cycle,
//  the match ripples along the row of Capacity cells
//  a result sits in the output register; a new request is taken when it is empty or
//  while the held result is being taken in the same cycle
//  rsp_o stalled with a result held: req_i.ready drops until it is taken
//  reset clears the count and the output valid; entries are not cleared,
//  only positions below the count are ever matched
// ----------------------------------------------------------------------------
module ordered_list_insert_remove
  import oli_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  oli_req_if.sink   req_i,
  oli_rsp_if.source rsp_o
);

  logic [CntW-1:0]        count_q, count_d;
  logic                   rsp_valid_q;
  logic [StW-1:0]         status_q, status_d;
  logic [LenW-1:0]        length_q;
  logic                   accept;
  logic                   full;
  logic                   found;
  cell_ctrl_t             ctrl;

  logic signed [ValW-1:0] cell_data [Capacity];
  logic                   cell_hit  [Capacity+1];

  // output register frees up when empty or when its result leaves now
  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign accept      = req_i.valid && req_i.ready;

  assign full  = count_q == CntW'(Capacity);
  assign found = cell_hit[Capacity];

  // decode the request into cell commands and the next count
  always_comb begin
    ctrl     = '0;
    count_d  = count_q;
    status_d = ST_DONE;
    case (op_e'(req_i.opcode))
      OP_INS_FRONT: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.shift_back = accept;
          count_d         = count_q + CntW'(1);
        end
      end
      OP_INS_BACK: begin
        if (full) begin
          status_d = ST_FULL;
        end else begin
          ctrl.append = accept;
          count_d     = count_q + CntW'(1);
        end
      end
      OP_REMOVE: begin
        if (found) begin
          ctrl.remove = accept;
          count_d     = count_q - CntW'(1);
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        // unused opcode: list unchanged, reported as done
        status_d = ST_DONE;
      end
    endcase
  end

  // row of cells, position 0 is the front
  assign cell_hit[0] = 1'b0;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [ValW-1:0] prev, next;

    if (i == 0) begin : g_first
      assign prev = req_i.value;
    end else begin : g_mid_prev
      assign prev = cell_data[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign next = cell_data[i];
    end else begin : g_mid_next
      assign next = cell_data[i+1];
    end

    oli_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IdxW'(i)),
      .count_i (count_q),
      .ctrl_i  (ctrl),
      .value_i (req_i.value),
      .prev_i  (prev),
      .next_i  (next),
      .hit_i   (cell_hit[i]),
      .hit_o   (cell_hit[i+1]),
      .data_o  (cell_data[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // result payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (accept) begin
      status_q <= status_d;
      length_q <= LenW'(count_d);
    end
  end

  assign rsp_o.valid  = rsp_valid_q;
  assign rsp_o.status = status_q;
  assign rsp_o.length = length_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("count beyond capacity");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && full && (req_i.opcode == OP_INS_FRONT || req_i.opcode == OP_INS_BACK)
    |=> rsp_o.valid && rsp_o.status == ST_FULL && $stable(count_q))
    else $error("insert into full list not dropped");

  a_not_found_keep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && req_i.opcode == OP_REMOVE && !found
    |=> rsp_o.status == ST_NOT_FOUND && $stable(count_q))
    else $error("failed remove changed the list");

  a_length_tracks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> rsp_o.length == LenW'(count_q))
    else $error("reported length differs from count");

  a_no_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !rsp_valid_q |-> req_i.ready)
    else $error("request stalled with empty output register");
`endif

endmodule

// File: tb/tb_ordered_list_insert_remove.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_insert_remove
// self-checking bench for the ordered list with front insert, back insert
// and remove of the first match; every request is predicted against a
// queue-based copy of the list and each result is checked in order
// ----------------------------------------------------------------------------
module tb_ordered_list_insert_remove;
  import oli_pkg::*;

  // opcode 3 has no name in the package, the list treats it as a no-op
  localparam logic [OpW-1:0] OpUnused   = 2'd3;
  localparam int             CalmTail   = 120;   // no new idle bursts start for the last requests
  localparam int             DrainWait  = 10;

  typedef struct packed {
    logic [OpW-1:0]  opcode;
    logic [ValW-1:0] value;
  } list_req_t;

  typedef struct packed {
    status_e         status;
    logic [LenW-1:0] length;
  } list_rsp_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  oli_req_if req_if ();
  oli_rsp_if rsp_if ();

  ordered_list_insert_remove DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  always #5 clk_i = ~clk_i;

  // requests waiting to be driven, filled up front by the stimulus block
  list_req_t       pending_reqs[$];
  // results the list must still produce, oldest first
  list_rsp_t       owed_results[$];
  // shadow of the list contents, position 0 is the front
  logic [ValW-1:0] shadow_list[$];

  int   total_reqs     = 0;
  int   accepted_reqs  = 0;
  int   mismatch_count = 0;
  int   req_gap_left   = 0;
  int   rsp_stall_left = 0;
  logic req_taken      = 1'b0;

  // ---------------------------------------------------------------------------
  // predictor: applies one request to the shadow list and returns the result
  // ---------------------------------------------------------------------------
  function automatic list_rsp_t apply_list_op(logic [OpW-1:0] op, logic [ValW-1:0] val);
    list_rsp_t res;
    int        hit;
    res.status = ST_DONE;
    hit        = -1;
    case (op)
      OP_INS_FRONT, OP_INS_BACK: begin
        // no room: the request is dropped and the list left alone
        if (shadow_list.size() >= Capacity) begin
          res.status = ST_FULL;
        end else if (op == OP_INS_FRONT) begin
          shadow_list.push_front(val);
        end else begin
          shadow_list.push_back(val);
        end
      end
      OP_REMOVE: begin
        // full 32-bit pattern compare, first match from the front wins
        foreach (shadow_list[i]) begin
          if (hit < 0 && shadow_list[i] == val) hit = i;
        end
        if (hit < 0) begin
          res.status = ST_NOT_FOUND;
        end else begin
          shadow_list.delete(hit);
        end
      end
      default: begin
        // unused opcode leaves the list as it is
      end
    endcase
    res.length = LenW'(shadow_list.size());
    return res;
  endfunction

  task automatic flag_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_req(logic [OpW-1:0] op, logic [ValW-1:0] val);
    list_req_t r;
    r.opcode = op;
    r.value  = val;
    pending_reqs.push_back(r);
    total_reqs++;
  endtask

  // ---------------------------------------------------------------------------
  // reset and known values on every input from time zero
  // ---------------------------------------------------------------------------
  initial begin
    req_if.valid  = 1'b0;
    req_if.opcode = '0;
    req_if.value  = '0;
    rsp_if.ready  = 1'b0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // request driver: changes at the falling edge, holds a request until taken
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    list_req_t r;
    if (rst_ni && (!req_if.valid || req_taken)) begin
      if (req_gap_left > 0) begin
        req_if.valid <= 1'b0;
        req_gap_left--;
      end else if (pending_reqs.size() > CalmTail && $urandom_range(0, 7) == 0) begin
        // idle burst starting with this one, req_gap_left holds the rest
        req_if.valid <= 1'b0;
        req_gap_left = $urandom_range(0, 10);
      end else if (pending_reqs.size() != 0) begin
        r = pending_reqs.pop_front();
        req_if.valid  <= 1'b1;
        req_if.opcode <= r.opcode;
        req_if.value  <= r.value;
      end else begin
        req_if.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: stalls in bursts, starts no new burst once the tail is reached
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (rsp_stall_left > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall_left--;
      end else if (pending_reqs.size() > CalmTail && $urandom_range(0, 6) == 0) begin
        rsp_if.ready <= 1'b0;
        rsp_stall_left = $urandom_range(0, 10);
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: samples both channels at the rising edge; the result is checked
  // before the new request is predicted, a result never answers a request
  // taken at the same edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_rsp_t want;
    req_taken <= rst_ni && req_if.valid && req_if.ready;
    if (rst_ni) begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (owed_results.size() == 0) begin
          flag_mismatch($sformatf("result with nothing owed: status %0d length %0d",
                                  rsp_if.status, rsp_if.length));
        end else begin
          want = owed_results.pop_front();
          if (rsp_if.status !== want.status)
            flag_mismatch($sformatf("status %0d, expected %0d", rsp_if.status, want.status));
          if (rsp_if.length !== want.length)
            flag_mismatch($sformatf("length %0d, expected %0d", rsp_if.length, want.length));
        end
      end
      if (req_if.valid && req_if.ready) begin
        owed_results.push_back(apply_list_op(req_if.opcode, req_if.value));
        accepted_reqs <= accepted_reqs + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    logic [ValW-1:0] pool[6];
    int              insert_pct;
    int              roll;
    logic [OpW-1:0]  op;
    logic [ValW-1:0] val;

    // directed part: empty list, extremes, no match, duplicates, full list
    queue_req(OP_REMOVE,    32'd5);          // remove from empty list
    queue_req(OpUnused,     32'hffff_ffff);  // unused opcode on empty list
    queue_req(OP_INS_FRONT, 32'h8000_0000);
    queue_req(OP_INS_BACK,  32'h7fff_ffff);
    queue_req(OP_INS_FRONT, 32'hffff_ffff);
    queue_req(OP_INS_BACK,  32'h0000_0000);
    queue_req(OP_REMOVE,    32'd12345);      // no match
    queue_req(OP_INS_BACK,  32'hffff_ffff);  // duplicate of the front entry
    queue_req(OP_REMOVE,    32'hffff_ffff);  // first of the two goes
    queue_req(OP_REMOVE,    32'h7fff_ffff);  // match in the middle
    // fill to capacity, then insert on a full list at both ends
    for (int i = 3; i < Capacity - 1; i++) begin
      queue_req((i % 2) ? OP_INS_FRONT : OP_INS_BACK, $urandom);
    end
    queue_req(OP_INS_BACK,  32'h5a5a_5a5a);
    queue_req(OP_INS_FRONT, 32'h1234_5678);
    queue_req(OP_INS_BACK,  32'h1234_5678);
    queue_req(OP_REMOVE,    32'h5a5a_5a5a);  // match at the back

    // random part: segments leaning toward filling, draining or balance,
    // values mostly from a small pool so removes often find a match
    for (int seg = 0; seg < 25; seg++) begin
      case ($urandom_range(0, 2))
        0:       insert_pct = 15;
        1:       insert_pct = 50;
        default: insert_pct = 85;
      endcase
      foreach (pool[k]) pool[k] = $urandom;
      if ($urandom_range(0, 2) == 0) pool[0] = 32'h8000_0000;
      if ($urandom_range(0, 2) == 0) pool[1] = 32'h7fff_ffff;
      for (int n = 0; n < 40; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) op = OpUnused;
        else if (roll < 3 + insert_pct) op = $urandom_range(0, 1) ? OP_INS_FRONT : OP_INS_BACK;
        else op = OP_REMOVE;
        val = ($urandom_range(0, 3) == 0) ? $urandom : pool[$urandom_range(0, 5)];
        queue_req(op, val);
      end
    end

    // all requests taken, then all results in, then a DrainWait pause
    while (accepted_reqs != total_reqs) @(posedge clk_i);
    while (owed_results.size() != 0) @(posedge clk_i);
    repeat (DrainWait) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // hang guard, far above the slowest legal run
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// File: ordered_list_insert_remove.f
src/oli_pkg.sv
src/oli_if.sv
src/oli_cell.sv
src/ordered_list_insert_remove.sv
tb/tb_ordered_list_insert_remove.sv
